[src/terhc_pkg.sv]
// Shared types, codes and constants for the thermo element ramp controller.
package terhc_pkg;

    localparam int DUTY_BITS = 8;
    localparam logic [7:0] DUTY_MASK = 8'((1 << DUTY_BITS) - 1);
    localparam logic [6:0] PCT_FULL = 7'd100;

    localparam int DIV_QBITS = 8;
    localparam int DIV_NBITS = 32;
    localparam int DIV_DBITS = 24;
    localparam int DIV_CBITS = $clog2(DIV_QBITS);

    localparam logic [1:0] MODE_STANDBY = 2'd0;
    localparam logic [1:0] MODE_HOT     = 2'd1;
    localparam logic [1:0] MODE_COLD    = 2'd2;

    localparam logic CMD_SET_MODE = 1'b0;
    localparam logic CMD_UPDATE   = 1'b1;

    localparam logic [2:0] CFG_HOT_LIMIT  = 3'd0;
    localparam logic [2:0] CFG_COLD_LIMIT = 3'd1;
    localparam logic [2:0] CFG_HYSTERESIS = 3'd2;
    localparam logic [2:0] CFG_RAMP_TIME  = 3'd3;
    localparam logic [2:0] CFG_MAX_DUTY   = 3'd4;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_PREP     = 9'b000000010,
        ST_ELAP     = 9'b000000100,
        ST_EVAL     = 9'b000001000,
        ST_LAUNCH_D = 9'b000010000,
        ST_WAIT_D   = 9'b000100000,
        ST_LAUNCH_P = 9'b001000000,
        ST_WAIT_P   = 9'b010000000,
        ST_DONE     = 9'b100000000
    } state_t;

    typedef struct packed {
        logic capture;
        logic apply_mode;
        logic calc_elapsed;
        logic evaluate;
        logic div_start;
        logic div_sel_pct;
        logic div_capture;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_duty_div;
        logic need_pct_div;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

[src/terhc_div.sv]
// Shared iterative restoring divider, one quotient bit per cycle.
module terhc_div
    import terhc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIV_NBITS-1:0] dividend,
    input  logic [DIV_DBITS-1:0] divisor,
    output logic                 done,
    output logic [DIV_QBITS-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CBITS-1:0] cnt_reg, cnt_next;
    logic [DIV_DBITS-1:0] rem_reg, rem_next;
    logic [DIV_QBITS-1:0] shq_reg, shq_next;
    logic [DIV_DBITS:0]   trial;
    logic [DIV_DBITS:0]   diff;
    logic                 qbit;

    assign trial = {rem_reg, shq_reg[DIV_QBITS-1]};
    assign diff  = trial - {1'b0, divisor};
    assign qbit  = (trial >= {1'b0, divisor});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        shq_next  = shq_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = dividend[DIV_NBITS-1:DIV_QBITS];
            shq_next  = dividend[DIV_QBITS-1:0];
        end else if (busy_reg) begin
            rem_next = qbit ? diff[DIV_DBITS-1:0] : trial[DIV_DBITS-1:0];
            shq_next = {shq_reg[DIV_QBITS-2:0], qbit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CBITS'(DIV_QBITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        shq_reg <= shq_next;
    end

    assign done     = done_reg;
    assign quotient = shq_reg;

endmodule

[src/terhc_ctrl.sv]
// Sequencer state machine for the thermo element ramp controller.
module terhc_ctrl
    import terhc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.capture = in_valid;
                if (in_valid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.apply_mode = 1'b1;
                state_next     = ST_ELAP;
            end
            ST_ELAP: begin
                cmd.calc_elapsed = 1'b1;
                state_next       = ST_EVAL;
            end
            ST_EVAL: begin
                cmd.evaluate = 1'b1;
                if (status.need_duty_div) begin
                    state_next = ST_LAUNCH_D;
                end else if (status.need_pct_div) begin
                    state_next = ST_LAUNCH_P;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_LAUNCH_D: begin
                cmd.div_start = 1'b1;
                state_next    = ST_WAIT_D;
            end
            ST_WAIT_D: begin
                cmd.div_capture = status.div_done;
                if (status.div_done) begin
                    state_next = ST_LAUNCH_P;
                end
            end
            ST_LAUNCH_P: begin
                cmd.div_start   = 1'b1;
                cmd.div_sel_pct = 1'b1;
                state_next      = ST_WAIT_P;
            end
            ST_WAIT_P: begin
                cmd.div_sel_pct = 1'b1;
                cmd.div_capture = status.div_done;
                if (status.div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                cmd.load_out = status.out_free;
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

[src/terhc_dpath.sv]
// Datapath: configuration, element state, ramp arithmetic and result register.
module terhc_dpath
    import terhc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_command,
    input  logic [1:0]  in_new_mode,
    input  logic [15:0] in_temperature,
    input  logic [31:0] in_now_ms,
    input  ctrl_cmd_t   cmd,
    output dp_status_t  status,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [23:0] out_data
);

    logic signed [15:0] hot_limit_reg;
    logic signed [15:0] cold_limit_reg;
    logic [14:0]        hysteresis_reg;
    logic [23:0]        ramp_time_reg;
    logic [7:0]         max_duty_reg;

    logic               command_reg;
    logic [1:0]         new_mode_reg;
    logic signed [15:0] temp_reg;
    logic [31:0]        now_reg;

    logic [1:0]  mode_reg, mode_next;
    logic        drive_reg, drive_next;
    logic        ramp_reg, ramp_next;
    logic [31:0] start_reg, start_next;
    logic [7:0]  duty_reg, duty_next;
    logic        dir_a_reg, dir_a_next;
    logic        dir_b_reg, dir_b_next;
    logic        enable_reg, enable_next;
    logic [6:0]  pct_reg, pct_next;

    logic [31:0] elapsed_reg;
    logic [31:0] prod_duty_reg;
    logic [31:0] prod_pct_reg;

    logic        out_valid_reg;
    logic [23:0] out_data_reg;

    logic               expired;
    logic               is_update;
    logic signed [17:0] temp_ext;
    logic signed [17:0] hy_ext;
    logic signed [17:0] hot_ext;
    logic signed [17:0] cold_ext;
    logic               hyst_drive;
    logic               div_done;
    logic [7:0]         div_q;
    logic [31:0]        div_dividend;

    assign is_update = (command_reg == CMD_UPDATE);
    assign expired   = (elapsed_reg >= {8'd0, ramp_time_reg});
    assign temp_ext  = {{2{temp_reg[15]}}, temp_reg};
    assign hy_ext    = {3'd0, hysteresis_reg};
    assign hot_ext   = {{2{hot_limit_reg[15]}}, hot_limit_reg};
    assign cold_ext  = {{2{cold_limit_reg[15]}}, cold_limit_reg};

    always_comb begin
        hyst_drive = 1'b0;
        unique case (mode_reg)
            MODE_HOT: begin
                if (drive_reg && temp_ext >= hot_ext + hy_ext) begin
                    hyst_drive = 1'b0;
                end else if (!drive_reg && temp_ext <= hot_ext - hy_ext) begin
                    hyst_drive = 1'b1;
                end else begin
                    hyst_drive = drive_reg;
                end
            end
            MODE_COLD: begin
                if (drive_reg && temp_ext <= cold_ext - hy_ext) begin
                    hyst_drive = 1'b0;
                end else if (!drive_reg && temp_ext >= cold_ext + hy_ext) begin
                    hyst_drive = 1'b1;
                end else begin
                    hyst_drive = drive_reg;
                end
            end
            default: begin
                hyst_drive = 1'b0;
            end
        endcase
    end

    always_comb begin
        mode_next   = mode_reg;
        drive_next  = drive_reg;
        ramp_next   = ramp_reg;
        start_next  = start_reg;
        duty_next   = duty_reg;
        dir_a_next  = dir_a_reg;
        dir_b_next  = dir_b_reg;
        enable_next = enable_reg;
        pct_next    = pct_reg;
        if (cmd.apply_mode && !is_update) begin
            if (new_mode_reg != mode_reg && new_mode_reg <= MODE_COLD) begin
                mode_next  = new_mode_reg;
                start_next = now_reg;
                if (new_mode_reg == MODE_STANDBY) begin
                    enable_next = 1'b0;
                    drive_next  = 1'b0;
                    ramp_next   = 1'b0;
                    duty_next   = '0;
                end else begin
                    enable_next = 1'b1;
                    drive_next  = 1'b1;
                    ramp_next   = 1'b1;
                end
            end
        end
        if (cmd.evaluate) begin
            pct_next = (ramp_reg && expired && !is_update) ? PCT_FULL : '0;
            if (is_update) begin
                if (ramp_reg) begin
                    drive_next = 1'b1;
                    if (expired) begin
                        duty_next = max_duty_reg & DUTY_MASK;
                        ramp_next = 1'b0;
                    end
                end else begin
                    drive_next = hyst_drive;
                    duty_next  = hyst_drive ? (max_duty_reg & DUTY_MASK) : '0;
                end
                if (mode_reg != MODE_STANDBY) begin
                    dir_a_next = (mode_reg == MODE_COLD);
                    dir_b_next = (mode_reg == MODE_HOT);
                end
            end
        end
        if (cmd.div_capture) begin
            if (cmd.div_sel_pct) begin
                pct_next = div_q[6:0];
            end else begin
                duty_next = div_q & DUTY_MASK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hot_limit_reg  <= 16'sd800;
            cold_limit_reg <= 16'sd160;
            hysteresis_reg <= 15'd16;
            ramp_time_reg  <= 24'd5000;
            max_duty_reg   <= 8'd255;
            mode_reg       <= MODE_STANDBY;
            drive_reg      <= 1'b0;
            ramp_reg       <= 1'b0;
            start_reg      <= '0;
            duty_reg       <= '0;
            dir_a_reg      <= 1'b0;
            dir_b_reg      <= 1'b0;
            enable_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (cfg_index)
                    CFG_HOT_LIMIT:  hot_limit_reg  <= cfg_data[15:0];
                    CFG_COLD_LIMIT: cold_limit_reg <= cfg_data[15:0];
                    CFG_HYSTERESIS: hysteresis_reg <= cfg_data[14:0];
                    CFG_RAMP_TIME:  ramp_time_reg  <= cfg_data;
                    CFG_MAX_DUTY:   max_duty_reg   <= cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            mode_reg   <= mode_next;
            drive_reg  <= drive_next;
            ramp_reg   <= ramp_next;
            start_reg  <= start_next;
            duty_reg   <= duty_next;
            dir_a_reg  <= dir_a_next;
            dir_b_reg  <= dir_b_next;
            enable_reg <= enable_next;
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        pct_reg <= pct_next;
        if (cmd.capture) begin
            command_reg  <= in_command;
            new_mode_reg <= in_new_mode;
            temp_reg     <= in_temperature;
            now_reg      <= in_now_ms;
        end
        if (cmd.calc_elapsed) begin
            elapsed_reg <= now_reg - start_reg;
        end
        if (cmd.evaluate) begin
            prod_duty_reg <= {8'd0, elapsed_reg[23:0]} * {24'd0, max_duty_reg};
            prod_pct_reg  <= {8'd0, elapsed_reg[23:0]} * {25'd0, PCT_FULL};
        end
        if (cmd.load_out) begin
            out_data_reg <= {2'b00, pct_reg, ramp_reg, enable_reg, dir_b_reg, dir_a_reg,
                             mode_reg, drive_reg, duty_reg};
        end
    end

    assign div_dividend = cmd.div_sel_pct ? prod_pct_reg : prod_duty_reg;

    terhc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (ramp_time_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign status.need_pct_div  = ramp_reg && !expired;
    assign status.need_duty_div = is_update && ramp_reg && !expired;
    assign status.div_done      = div_done;
    assign status.out_free      = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[src/thermo_element_ramp_hysteresis_ctrl.sv]
// Top level of the thermo element controller with soft-start ramp and hysteresis.
//
//  channel  direction  ports                                    content
//  s_       in         s_tvalid s_tready s_tdata[55:0] s_tuser  one command transaction
//  m_       out        m_tvalid m_tready m_tdata[23:0]          element state after it
//  cfg_     in         cfg_valid cfg_ready cfg_index cfg_data   register write
//
// One item at a time; while the ramp runs, a set-mode item takes one divider pass
// and an update takes two, else none; each divider pass has 8 steps.
// A finished result waits in the output register while the next item is taken.
// aresetn is synchronous; it restores register defaults and standby state.
// A stalled m_ side blocks only the final write of the next result.
module thermo_element_ramp_hysteresis_ctrl
    import terhc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // new_mode[1:0], temperature[17:2], now_ms[49:18]
    input  logic        s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // duty[7:0], heater_on[8], active_mode[10:9], dir_a[11],
                                   // dir_b[12], bridge_enable[13], ramping_now[14],
                                   // ramp_percent[21:15]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    terhc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    terhc_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr         (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_command     (s_tuser),
        .in_new_mode    (s_tdata[1:0]),
        .in_temperature (s_tdata[17:2]),
        .in_now_ms      (s_tdata[49:18]),
        .cmd            (cmd),
        .status         (status),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .out_data       (m_tdata)
    );

endmodule

[src/terhc_checker.sv]
// Port-level checker for the thermo element controller, bound to the top level.
module terhc_checker
    import terhc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_standby_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[10:9] == MODE_STANDBY |->
            m_tdata[7:0] == 8'd0 && !m_tdata[8] && !m_tdata[13] && !m_tdata[14])
        else $error("element driven in standby");

    a_ramp_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[14] |-> m_tdata[8] && m_tdata[13])
        else $error("ramp running without drive");

    a_pct_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[14] |-> m_tdata[21:15] == 7'd0)
        else $error("ramp percent set with no ramp");

endmodule

bind thermo_element_ramp_hysteresis_ctrl terhc_checker u_terhc_checker (.*);

[sim/tb_thermo_element_ramp_hysteresis_ctrl.sv]
// Self-checking testbench for the thermo element ramp and hysteresis controller.
module tb_thermo_element_ramp_hysteresis_ctrl;
    timeunit 1ns;
    timeprecision 1ps;
    import terhc_pkg::*;

    localparam int QUIET_LIMIT = 5000;

    typedef struct packed {
        logic [1:0] pad;
        logic [6:0] ramp_percent;
        logic       ramping_now;
        logic       bridge_enable;
        logic       dir_b;
        logic       dir_a;
        logic [1:0] active_mode;
        logic       heater_on;
        logic [7:0] duty;
    } element_state_t;

    class thermo_state_tracker;
        logic signed [15:0] hot_lim;
        logic signed [15:0] cold_lim;
        logic [14:0]        hyst;
        logic [23:0]        ramp_ms;
        logic [7:0]         full_duty;
        logic [1:0]         mode;
        logic               drive;
        logic               ramping;
        logic [31:0]        ramp_t0;
        logic [7:0]         duty;
        logic               dir_a;
        logic               dir_b;
        logic               enable;
        element_state_t     due_states[$];
        int                 errors;

        function new();
            hot_lim   = 16'sd800;
            cold_lim  = 16'sd160;
            hyst      = 15'd16;
            ramp_ms   = 24'd5000;
            full_duty = 8'd255;
            mode      = MODE_STANDBY;
            drive     = 1'b0;
            ramping   = 1'b0;
            ramp_t0   = '0;
            duty      = '0;
            dir_a     = 1'b0;
            dir_b     = 1'b0;
            enable    = 1'b0;
            errors    = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [23:0] data);
            case (idx)
                CFG_HOT_LIMIT:  hot_lim   = data[15:0];
                CFG_COLD_LIMIT: cold_lim  = data[15:0];
                CFG_HYSTERESIS: hyst      = data[14:0];
                CFG_RAMP_TIME:  ramp_ms   = data;
                CFG_MAX_DUTY:   full_duty = data[7:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return due_states.size();
        endfunction

        function void note_command(logic cmd, logic [1:0] nm, logic signed [15:0] temp,
                                   logic [31:0] now);
            logic [31:0]    elapsed;
            logic [63:0]    prod;
            int             t;
            int             hy;
            int             hl;
            int             cl;
            element_state_t s;
            t  = temp;
            hy = hyst;
            hl = hot_lim;
            cl = cold_lim;
            if (cmd == CMD_SET_MODE) begin
                if (nm != mode && nm <= MODE_COLD) begin
                    mode    = nm;
                    ramping = 1'b1;
                    ramp_t0 = now;
                    drive   = 1'b1;
                    enable  = 1'b1;
                    if (nm == MODE_STANDBY) begin
                        enable  = 1'b0;
                        drive   = 1'b0;
                        ramping = 1'b0;
                        duty    = '0;
                    end
                end
            end else begin
                if (ramping) begin
                    elapsed = now - ramp_t0;
                    if (elapsed >= 32'(ramp_ms)) begin
                        duty    = full_duty & DUTY_MASK;
                        ramping = 1'b0;
                    end else begin
                        prod = 64'(elapsed) * 64'(full_duty);
                        duty = 8'(prod / 64'(ramp_ms)) & DUTY_MASK;
                    end
                    drive = 1'b1;
                end else begin
                    case (mode)
                        MODE_HOT: begin
                            if (drive && t >= hl + hy) drive = 1'b0;
                            else if (!drive && t <= hl - hy) drive = 1'b1;
                        end
                        MODE_COLD: begin
                            if (drive && t <= cl - hy) drive = 1'b0;
                            else if (!drive && t >= cl + hy) drive = 1'b1;
                        end
                        default: drive = 1'b0;
                    endcase
                    duty = drive ? (full_duty & DUTY_MASK) : '0;
                end
                if (mode != MODE_STANDBY) begin
                    dir_a = (mode == MODE_COLD);
                    dir_b = (mode == MODE_HOT);
                end
            end
            elapsed = now - ramp_t0;
            s = '0;
            s.duty          = duty;
            s.heater_on     = drive;
            s.active_mode   = mode;
            s.dir_a         = dir_a;
            s.dir_b         = dir_b;
            s.bridge_enable = enable;
            s.ramping_now   = ramping;
            if (!ramping) s.ramp_percent = '0;
            else if (elapsed >= 32'(ramp_ms)) s.ramp_percent = PCT_FULL;
            else s.ramp_percent = 7'((64'(elapsed) * 64'd100) / 64'(ramp_ms));
            due_states.push_back(s);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_state(logic [23:0] raw);
            element_state_t want;
            element_state_t got;
            if (due_states.size() == 0) begin
                $display("%0t: unexpected result expected none got %h", $time, raw);
                errors++;
                return;
            end
            want = due_states.pop_front();
            got  = raw;
            compare_field("duty", want.duty, got.duty);
            compare_field("heater_on", want.heater_on, got.heater_on);
            compare_field("active_mode", want.active_mode, got.active_mode);
            compare_field("dir_a", want.dir_a, got.dir_a);
            compare_field("dir_b", want.dir_b, got.dir_b);
            compare_field("bridge_enable", want.bridge_enable, got.bridge_enable);
            compare_field("ramping_now", want.ramping_now, got.ramping_now);
            compare_field("ramp_percent", want.ramp_percent, got.ramp_percent);
            compare_field("pad", want.pad, got.pad);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    thermo_state_tracker sb = new();
    logic [31:0]         clock_ms = '0;
    int                  sent = 0;
    int                  rx_count = 0;

    thermo_element_ramp_hysteresis_ctrl dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic send_cmd(logic cmd, logic [1:0] nm, logic signed [15:0] temp,
                            logic [31:0] now);
        if (sent < 500 || sent >= 650) begin
            while ($urandom_range(99) < 34) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'b0, now, temp, nm};
        do @(posedge aclk); while (!s_tready);
        sb.note_command(cmd, nm, temp, now);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic set_regs(logic [15:0] hot, logic [15:0] cold, logic [14:0] hy,
                            logic [23:0] rt, logic [7:0] md);
        logic [2:0]  idx [5];
        logic [23:0] vals [5];
        idx  = '{CFG_HOT_LIMIT, CFG_COLD_LIMIT, CFG_HYSTERESIS, CFG_RAMP_TIME, CFG_MAX_DUTY};
        vals = '{24'(hot), 24'(cold), 24'(hy), rt, 24'(md)};
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.write_reg(idx[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] pick_temp();
        int k;
        int lim;
        int hy;
        int v;
        k  = $urandom_range(99);
        hy = sb.hyst;
        if (k < 55) begin
            if (sb.mode == MODE_COLD || (sb.mode == MODE_STANDBY && $urandom_range(1) == 1))
                lim = sb.cold_lim;
            else
                lim = sb.hot_lim;
            v = lim - (hy + 4) + int'($urandom_range(2 * hy + 8));
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return 16'(v);
        end
        if (k < 88) return 16'($urandom);
        if (k < 94) return 16'sh8000;
        return 16'sh7FFF;
    endfunction

    task automatic run_random(int count);
        logic       cmd;
        logic [1:0] nm;
        int         k;
        int         rt;
        for (int i = 0; i < count; i++) begin
            rt  = sb.ramp_ms;
            cmd = ($urandom_range(99) < 12) ? CMD_SET_MODE : CMD_UPDATE;
            nm  = ($urandom_range(7) == 0) ? 2'd3 : 2'($urandom_range(2));
            k   = $urandom_range(99);
            if (k < 8) clock_ms = $urandom;
            else if (k < 11) clock_ms = 32'hFFFF_FFFF - $urandom_range(rt);
            else if (k < 20) clock_ms = clock_ms + rt + $urandom_range(rt);
            else clock_ms = clock_ms + $urandom_range(rt / 3 + 1);
            send_cmd(cmd, nm, pick_temp(), clock_ms);
        end
    endtask

    initial begin : result_sink
        int   hold_left;
        bit   held;
        logic ready_next;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                sb.check_state(m_tdata);
                rx_count++;
            end
            if (!held && rx_count == 300) begin
                held      = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (rx_count >= 500 && rx_count < 650) begin
                ready_next = 1'b1;
            end else begin
                ready_next = ($urandom_range(99) >= 34);
            end
            m_tready <= ready_next;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default registers: standby, same mode, ignored code, hot ramp, hysteresis
        send_cmd(CMD_UPDATE, 2'd0, 16'sd0, 32'd0);
        send_cmd(CMD_SET_MODE, MODE_STANDBY, 16'sh7FFF, 32'd100);
        send_cmd(CMD_SET_MODE, 2'd3, 16'sh8000, 32'd200);
        send_cmd(CMD_SET_MODE, MODE_HOT, 16'sd0, 32'd1000);
        send_cmd(CMD_UPDATE, 2'd3, 16'sh7FFF, 32'd1000);
        send_cmd(CMD_UPDATE, 2'd0, 16'sd0, 32'd3500);
        send_cmd(CMD_UPDATE, 2'd0, 16'sd0, 32'd5999);
        send_cmd(CMD_UPDATE, 2'd0, 16'sd0, 32'd6000);
        send_cmd(CMD_UPDATE, 2'd0, 16'sd816, 32'd6100);
        send_cmd(CMD_UPDATE, 2'd0, 16'sd785, 32'd6200);
        send_cmd(CMD_UPDATE, 2'd0, 16'sd784, 32'd6300);
        send_cmd(CMD_SET_MODE, MODE_HOT, 16'sd0, 32'd6400);
        // cold ramp across the timestamp wrap
        send_cmd(CMD_SET_MODE, MODE_COLD, 16'sd0, 32'hFFFF_F000);
        send_cmd(CMD_UPDATE, 2'd0, 16'sd0, 32'h0000_0100);
        send_cmd(CMD_UPDATE, 2'd0, 16'sd0, 32'h0000_0400);
        send_cmd(CMD_UPDATE, 2'd0, 16'sd144, 32'h0000_0500);
        send_cmd(CMD_UPDATE, 2'd0, 16'sd175, 32'h0000_0600);
        send_cmd(CMD_UPDATE, 2'd0, 16'sd176, 32'h0000_0700);
        send_cmd(CMD_UPDATE, 2'd0, 16'sh8000, 32'h0000_0800);
        send_cmd(CMD_UPDATE, 2'd0, 16'sh7FFF, 32'h0000_0900);
        send_cmd(CMD_SET_MODE, MODE_STANDBY, 16'sd0, 32'h0000_0A00);
        send_cmd(CMD_UPDATE, 2'd3, 16'sh7FFF, 32'hFFFF_FFFF);
        send_cmd(CMD_SET_MODE, 2'd3, 16'shFFFF, 32'hFFFF_FFFF);
        drain();

        set_regs(16'h8000, 16'h7FFF, 15'd0, 24'd1, 8'd0);
        run_random(200);
        drain();

        set_regs(16'h7FFF, 16'h8000, 15'h7FFF, 24'hFF_FFFF, 8'd255);
        run_random(200);
        drain();

        // zero ramp time: percent reads full while the ramp flag is set
        set_regs(16'($urandom), 16'($urandom), 15'd8, 24'd0, 8'($urandom));
        send_cmd(CMD_SET_MODE, MODE_STANDBY, 16'sd0, clock_ms);
        send_cmd(CMD_SET_MODE, MODE_COLD, 16'sd0, clock_ms);
        send_cmd(CMD_UPDATE, 2'd0, 16'sd0, clock_ms);
        run_random(150);
        drain();

        set_regs(16'($urandom), 16'($urandom), 15'($urandom_range(300)),
                 24'($urandom_range(3000, 2)), 8'($urandom));
        run_random(250);
        drain();

        set_regs(16'($urandom_range(1200)), 16'($urandom_range(400)),
                 15'($urandom_range(64)), 24'($urandom_range(20000, 100)), 8'($urandom));
        run_random(200);
        drain();

        repeat (30) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
src/terhc_pkg.sv
src/terhc_div.sv
src/terhc_ctrl.sv
src/terhc_dpath.sv
src/thermo_element_ramp_hysteresis_ctrl.sv
src/terhc_checker.sv
sim/tb_thermo_element_ramp_hysteresis_ctrl.sv
